FILE: hw/rtl/multichannel_rolling_average_unit_assert.svh
// Assertion helpers for the rolling average block.
// The enclosing module provides the clock and reset signals by those names.
`ifndef MULTICHANNEL_ROLLING_AVERAGE_UNIT_ASSERT_SVH
`define MULTICHANNEL_ROLLING_AVERAGE_UNIT_ASSERT_SVH

// cons holds in the same cycle as ante
`define MRA_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// cons holds in the cycle after ante
`define MRA_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hw/rtl/mra_pkg.sv
`default_nettype none

package mra_pkg;

   // default sizing
   localparam int WINDOW_DEF       = 5;
   localparam int MAX_CHANNELS_DEF = 16;

   // field widths
   localparam int ID_W       = 6;
   localparam int ECHO_W     = 20;
   localparam int MEAN_W     = 24;
   localparam int SLOT_OUT_W = 4;
   localparam int Q_FRAC     = 4;

   localparam logic [ECHO_W-1:0] DEFAULT_DIST_RST = 20'd1000;

   typedef struct packed {
      logic [ID_W-1:0]   channel_id;
      logic [ECHO_W-1:0] echo_width;
   } mra_req_type;

   typedef struct packed {
      logic [MEAN_W-1:0]     mean_q4;
      logic                  is_default;
      logic [SLOT_OUT_W-1:0] slot_used;
      logic                  registry_full;
   } mra_rsp_type;

endpackage

`default_nettype wire

FILE: hw/rtl/multichannel_rolling_average_unit.sv
// Per-channel rolling average of ultrasonic echo widths. Each item carries a
// channel id and an echo width. The id is matched against a registry of up to
// MAX_CHANNELS slots; a new id claims the next free slot (its window starts
// empty), and once every slot is taken an unknown id lands in slot 0 with
// registry_full set. The echo goes into the slot's circular window of WINDOW
// samples. Once the window is full the result is floor(sum*16/WINDOW) in
// unsigned Q4; during warm-up, or if the window sums to zero, the result is
// csr default_distance*16 with is_default set. One item is in flight at a
// time: req_stall is high from acceptance until the result is handed to the
// output register, which may still hold the previous result. Steps per item:
// accept; for each registry slot examined, a key memory read (one read port)
// and a compare; then claim a slot or fetch the slot pointers (when the
// registry is full: fall back to slot 0, then fetch); then update. Warm-up
// items then go to the output register. Full windows first sum the window
// (one sample memory read per cycle) and, unless the sum is zero, pass the
// divider (operand register, then reciprocal product). No memory sweep follows
// reset: window contents are only summed after WINDOW fresh writes.
`default_nettype none
`include "multichannel_rolling_average_unit_assert.svh"

module multichannel_rolling_average_unit #(
   parameter int WINDOW       = mra_pkg::WINDOW_DEF,
   parameter int MAX_CHANNELS = mra_pkg::MAX_CHANNELS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   // item in
   input  logic                          req_valid,
   output logic                          req_stall,
   input  mra_pkg::mra_req_type          req_item,
   // result out
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output mra_pkg::mra_rsp_type          rsp_item,
   // default distance register
   input  logic                          csr_wr_en,
   input  logic [mra_pkg::ECHO_W-1:0]    csr_wr_data
);
   import mra_pkg::*;

   localparam int SLOT_W   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
   localparam int IU_W     = $clog2(MAX_CHANNELS + 1);
   localparam int POS_W    = $clog2(WINDOW);
   localparam int FILL_W   = $clog2(WINDOW + 1);
   localparam int K_W      = $clog2(WINDOW + 1);
   localparam int ST_DEPTH = MAX_CHANNELS * WINDOW;
   localparam int ST_AW    = $clog2(ST_DEPTH);
   localparam int SUM_W    = ECHO_W + $clog2(WINDOW);
   localparam int DVD_W    = SUM_W + Q_FRAC;

   typedef enum logic [2:0] {
      S_IDLE,
      S_KEY_RD,   // key memory read in flight
      S_KEY_CMP,  // compare key against item id
      S_ALLOC,    // id unknown: claim a slot or fall back to slot 0
      S_META_RD,  // pointer memory read in flight
      S_UPDATE,   // store sample, advance pointers
      S_SUM,      // accumulate window, one sample per cycle
      S_DIV       // wait on divider
   } state_type;

   // A finished result waits in S_IDLE with done_ff set until the output
   // register is free; the handoff is driven by that flag below.

   typedef struct packed {
      logic [POS_W-1:0]  pos;
      logic [FILL_W-1:0] fill;
   } meta_type;

   state_type          state_ff;
   logic [ECHO_W-1:0]  dflt_ff;
   logic [ID_W-1:0]    id_ff;
   logic [ECHO_W-1:0]  smp_ff;
   logic [SLOT_W-1:0]  idx_ff;
   logic [IU_W-1:0]    in_use_ff;
   logic [SLOT_W-1:0]  slot_ff;
   logic               new_ff;
   logic               full_ff;
   logic               use_dflt_ff;
   logic               done_ff;     // result computed, waiting for output register
   logic [ST_AW-1:0]   base_ff;
   logic [K_W-1:0]     k_ff;
   logic [SUM_W-1:0]   sum_ff;
   logic [MEAN_W-1:0]  mean_ff;
   logic               rsp_valid_ff;
   mra_rsp_type        rsp_item_ff;

   // memories
   logic [ID_W-1:0]    key_mem [MAX_CHANNELS];
   logic [ID_W-1:0]    key_q;
   meta_type           meta_mem [MAX_CHANNELS];
   meta_type           meta_q;
   logic [ECHO_W-1:0]  st_mem [ST_DEPTH];
   logic [ECHO_W-1:0]  st_q;

   logic               key_hit;
   logic               idx_last;
   logic               has_free;
   logic               key_we;
   logic               upd_we;
   logic [POS_W-1:0]   cur_pos;
   logic [FILL_W-1:0]  cur_fill;
   meta_type           meta_nxt;
   logic [ST_AW-1:0]   base_in;
   logic [ST_AW-1:0]   st_waddr;
   logic [ST_AW-1:0]   st_raddr;
   logic [SUM_W-1:0]   sum_in;
   logic               sum_last;
   logic               div_start;
   logic               div_done;
   logic [DVD_W-1:0]   div_quot;
   logic               out_free;

   assign key_hit  = (key_q == id_ff);
   assign idx_last = ((IU_W'(idx_ff) + IU_W'(1)) == in_use_ff);
   assign has_free = (in_use_ff < IU_W'(MAX_CHANNELS));
   assign key_we   = (state_ff == S_ALLOC) && has_free;
   assign upd_we   = (state_ff == S_UPDATE);

   // a freshly claimed slot starts empty; its stale pointers are ignored
   assign cur_pos       = new_ff ? '0 : meta_q.pos;
   assign cur_fill      = new_ff ? '0 : meta_q.fill;
   assign meta_nxt.pos  = (cur_pos == POS_W'(WINDOW - 1)) ? '0 : cur_pos + 1'b1;
   assign meta_nxt.fill = (cur_fill < FILL_W'(WINDOW)) ? cur_fill + 1'b1 : cur_fill;

   assign base_in  = ST_AW'(slot_ff * WINDOW);
   assign st_waddr = base_in + ST_AW'(cur_pos);
   assign sum_last = (k_ff == K_W'(WINDOW));
   assign st_raddr = sum_last ? base_ff : base_ff + ST_AW'(k_ff);
   // data for sample k-1 arrives while sample k is being addressed
   assign sum_in   = (k_ff != '0) ? sum_ff + SUM_W'(st_q) : sum_ff;

   assign div_start = (state_ff == S_SUM) && sum_last && (sum_in != '0);
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (key_we) begin
         key_mem[SLOT_W'(in_use_ff)] <= id_ff;
      end
      key_q <= key_mem[idx_ff];
   end

   always_ff @(posedge clock) begin
      if (upd_we) begin
         meta_mem[slot_ff] <= meta_nxt;
      end
      meta_q <= meta_mem[slot_ff];
   end

   always_ff @(posedge clock) begin
      if (upd_we) begin
         st_mem[st_waddr] <= smp_ff;
      end
      st_q <= st_mem[st_raddr];
   end

   mra_qdiv #(
      .WINDOW (WINDOW),
      .DVD_W  (DVD_W)
   ) u_qdiv (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend ({sum_in, {Q_FRAC{1'b0}}}),
      .done     (div_done),
      .quotient (div_quot)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         dflt_ff      <= DEFAULT_DIST_RST;
         in_use_ff    <= '0;
         done_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            dflt_ff <= csr_wr_data;
         end

         // finished result moves to the output register when it is free
         if (done_ff && out_free) begin
            done_ff                   <= 1'b0;
            rsp_valid_ff              <= 1'b1;
            rsp_item_ff.mean_q4       <= use_dflt_ff ?
                                         MEAN_W'({dflt_ff, {Q_FRAC{1'b0}}}) : mean_ff;
            rsp_item_ff.is_default    <= use_dflt_ff;
            rsp_item_ff.slot_used     <= SLOT_OUT_W'(slot_ff);
            rsp_item_ff.registry_full <= full_ff;
            state_ff                  <= S_IDLE;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            S_IDLE: begin
               if (req_valid && !done_ff) begin
                  id_ff    <= req_item.channel_id;
                  smp_ff   <= req_item.echo_width;
                  idx_ff   <= '0;
                  new_ff   <= 1'b0;
                  full_ff  <= 1'b0;
                  state_ff <= (in_use_ff == '0) ? S_ALLOC : S_KEY_RD;
               end
            end
            S_KEY_RD: begin
               state_ff <= S_KEY_CMP;
            end
            S_KEY_CMP: begin
               priority if (key_hit) begin
                  slot_ff  <= idx_ff;
                  state_ff <= S_META_RD;
               end else if (idx_last) begin
                  state_ff <= S_ALLOC;
               end else begin
                  idx_ff   <= idx_ff + 1'b1;
                  state_ff <= S_KEY_RD;
               end
            end
            S_ALLOC: begin
               if (has_free) begin
                  slot_ff   <= SLOT_W'(in_use_ff);
                  in_use_ff <= in_use_ff + 1'b1;
                  new_ff    <= 1'b1;
                  state_ff  <= S_UPDATE;
               end else begin
                  slot_ff  <= '0;
                  full_ff  <= 1'b1;
                  state_ff <= S_META_RD;
               end
            end
            S_META_RD: begin
               state_ff <= S_UPDATE;
            end
            S_UPDATE: begin
               base_ff <= base_in;
               k_ff    <= '0;
               sum_ff  <= '0;
               if (meta_nxt.fill < FILL_W'(WINDOW)) begin
                  use_dflt_ff <= 1'b1;
                  done_ff     <= 1'b1;
                  state_ff    <= S_IDLE;
               end else begin
                  use_dflt_ff <= 1'b0;
                  state_ff    <= S_SUM;
               end
            end
            S_SUM: begin
               sum_ff <= sum_in;
               if (sum_last) begin
                  if (sum_in == '0) begin
                     use_dflt_ff <= 1'b1;
                     done_ff     <= 1'b1;
                     state_ff    <= S_IDLE;
                  end else begin
                     state_ff <= S_DIV;
                  end
               end else begin
                  k_ff <= k_ff + 1'b1;
               end
            end
            S_DIV: begin
               if (div_done) begin
                  mean_ff  <= MEAN_W'(div_quot);
                  done_ff  <= 1'b1;
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   // idle only when no finished result is parked
   assign req_stall = (state_ff != S_IDLE) || done_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   `MRA_ASSERT_NOW(a_div_done_in_div, div_done, state_ff == S_DIV, "divider done outside S_DIV")
   `MRA_ASSERT_NOW(a_in_use_bound, 1'b1, in_use_ff <= IU_W'(MAX_CHANNELS), "slot count overflow")
   `MRA_ASSERT_NEXT(a_alloc_counts, key_we, in_use_ff == IU_W'($past(in_use_ff) + 1'b1), "claim without count")
   `MRA_ASSERT_NOW(a_mean_nonzero, rsp_valid_ff && !rsp_item_ff.is_default, rsp_item_ff.mean_q4 != '0, "zero mean not defaulted")
   `MRA_ASSERT_NOW(a_rose_from_done, $rose(rsp_valid_ff), $past(done_ff), "result without finished item")

endmodule

`default_nettype wire

FILE: hw/rtl/mra_qdiv.sv
`default_nettype none

// Divide by the constant WINDOW with a reciprocal multiply.
// Operand register, then product register; done is registered alongside the product.
module mra_qdiv #(
   parameter int WINDOW = mra_pkg::WINDOW_DEF,
   parameter int DVD_W  = mra_pkg::ECHO_W + $clog2(mra_pkg::WINDOW_DEF) + mra_pkg::Q_FRAC
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DVD_W-1:0] dividend,
   output logic             done,
   output logic [DVD_W-1:0] quotient
);
   import mra_pkg::*;

   // floor(x / WINDOW) == (x * RCP) >> SHIFT for every x below 2**DVD_W
   localparam int               SHIFT  = DVD_W + $clog2(WINDOW);
   localparam int               RCP_W  = DVD_W + 1;
   localparam int               PROD_W = DVD_W + RCP_W;
   localparam logic [RCP_W-1:0] RCP    =
      RCP_W'(((64'd1 << SHIFT) + 64'(WINDOW) - 64'd1) / 64'(WINDOW));

   logic [DVD_W-1:0]  dvd_ff;
   logic [PROD_W-1:0] prod_ff;
   logic              busy_ff;
   logic              done_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= start;
         done_ff <= busy_ff;
         if (start) begin
            dvd_ff <= dividend;
         end
         if (busy_ff) begin
            prod_ff <= PROD_W'(dvd_ff) * PROD_W'(RCP);
         end
      end
   end

   assign done     = done_ff;
   assign quotient = DVD_W'(prod_ff[PROD_W-1:SHIFT]);

endmodule

`default_nettype wire

FILE: test/rolling_average_checker.sv
`timescale 1ns / 100ps

module rolling_average_checker (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_stall,
   input  mra_pkg::mra_req_type req_item,
   input  logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  mra_pkg::mra_rsp_type rsp_item,
   input  logic                 csr_wr_en,
   input  logic [mra_pkg::ECHO_W-1:0] csr_wr_data,
   output int                   outstanding,
   output int                   fail_count
);
   import mra_pkg::*;

   localparam int WINDOW       = WINDOW_DEF;
   localparam int MAX_CHANNELS = MAX_CHANNELS_DEF;

   // shadow of the block's registry and windows
   logic [ECHO_W-1:0] default_distance;
   logic [ID_W-1:0]   chan_key [MAX_CHANNELS];
   int                chans_registered;
   logic [ECHO_W-1:0] echo_window [MAX_CHANNELS][WINDOW];
   int                wr_pos [MAX_CHANNELS];
   int                samples_held [MAX_CHANNELS];
   mra_rsp_type       expected_means [$];

   function automatic void clear_window(input int slot);
      int k;
      for (k = 0; k < WINDOW; k++) echo_window[slot][k] = '0;
      wr_pos[slot]       = 0;
      samples_held[slot] = 0;
   endfunction

   // registry lookup, window update and Q4 mean for one item
   function automatic mra_rsp_type average_for(input mra_req_type item);
      mra_rsp_type res;
      int          slot;
      int          k;
      bit          hit;
      logic [31:0] sum;
      res  = '0;
      slot = 0;
      hit  = 1'b0;
      sum  = '0;
      for (k = 0; k < chans_registered; k++) begin
         if (!hit && chan_key[k] == item.channel_id) begin
            slot = k;
            hit  = 1'b1;
         end
      end
      if (!hit) begin
         if (chans_registered < MAX_CHANNELS) begin
            slot           = chans_registered;
            chan_key[slot] = item.channel_id;
            clear_window(slot);
            chans_registered++;
         end else begin
            // no free slot: share slot 0, its window is kept
            res.registry_full = 1'b1;
         end
      end
      echo_window[slot][wr_pos[slot]] = item.echo_width;
      wr_pos[slot] = (wr_pos[slot] == WINDOW - 1) ? 0 : wr_pos[slot] + 1;
      if (samples_held[slot] < WINDOW) samples_held[slot]++;
      if (samples_held[slot] == WINDOW) begin
         for (k = 0; k < WINDOW; k++) sum += echo_window[slot][k];
      end
      if (samples_held[slot] < WINDOW || sum == 0) begin
         res.is_default = 1'b1;
         res.mean_q4    = {default_distance, 4'b0000};
      end else begin
         res.mean_q4 = MEAN_W'((sum * 16) / WINDOW);
      end
      res.slot_used = SLOT_OUT_W'(slot);
      return res;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("%0t: MISMATCH %s", $time, msg);
      fail_count++;
   endtask

   always @(posedge clock) begin : watch
      mra_rsp_type want;
      int          k;
      if (reset) begin
         default_distance = DEFAULT_DIST_RST;
         chans_registered = 0;
         fail_count       = 0;
         for (k = 0; k < MAX_CHANNELS; k++) begin
            chan_key[k] = '0;
            clear_window(k);
         end
         expected_means.delete();
      end else begin
         if (csr_wr_en) default_distance = csr_wr_data;
         if (rsp_valid && !rsp_stall) begin
            if (expected_means.size() == 0) begin
               report_mismatch($sformatf("result %0h with nothing pending", rsp_item));
            end else begin
               want = expected_means.pop_front();
               if (rsp_item.mean_q4 !== want.mean_q4)
                  report_mismatch($sformatf("mean_q4 got %0h expected %0h",
                                            rsp_item.mean_q4, want.mean_q4));
               if (rsp_item.is_default !== want.is_default)
                  report_mismatch($sformatf("is_default got %0b expected %0b",
                                            rsp_item.is_default, want.is_default));
               if (rsp_item.slot_used !== want.slot_used)
                  report_mismatch($sformatf("slot_used got %0d expected %0d",
                                            rsp_item.slot_used, want.slot_used));
               if (rsp_item.registry_full !== want.registry_full)
                  report_mismatch($sformatf("registry_full got %0b expected %0b",
                                            rsp_item.registry_full, want.registry_full));
            end
         end
         if (req_valid && !req_stall) expected_means.push_back(average_for(req_item));
      end
      outstanding <= expected_means.size();
   end

endmodule

FILE: test/multichannel_rolling_average_unit_tb.sv
`timescale 1ns / 100ps

module multichannel_rolling_average_unit_tb;
   import mra_pkg::*;

   localparam int CHUNKS       = 4;       // random phases, one default setting each
   localparam int CHUNK_ITEMS  = 450;
   localparam int HOLD_AT      = 400;     // item count that triggers the long hold-off
   localparam int LONG_HOLD    = 300;     // cycles of output back-pressure
   localparam int DRAIN_CYCLES = 60;      // margin above the worst item latency
   localparam int CYCLE_LIMIT  = 1500000;

   logic              clock       = 1'b0;
   logic              reset       = 1'b1;
   logic              req_valid   = 1'b0;
   logic              req_stall;
   mra_req_type       req_item    = '0;
   logic              rsp_valid;
   logic              rsp_stall   = 1'b0;
   mra_rsp_type       rsp_item;
   logic              csr_wr_en   = 1'b0;
   logic [ECHO_W-1:0] csr_wr_data = '0;

   int items_sent  = 0;
   int cycle_count = 0;
   int outstanding;            // results still owed by the block, from the checker
   int fail_count;
   bit tx_calm     = 1'b0;     // sender runs back to back while set

   always #5 clock = ~clock;

   multichannel_rolling_average_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_item    (req_item),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_item    (rsp_item),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   rolling_average_checker checker_i (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_item    (req_item),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_item    (rsp_item),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .outstanding (outstanding),
      .fail_count  (fail_count)
   );

   // Idle length: mostly none or short, now and then long; zero while calm.
   function automatic int unsigned gap_len(input bit calm);
      int unsigned r;
      r = $urandom_range(0, 99);
      if (calm || r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Offer one item and return at the edge that accepts it. Valid is left
   // high so a back-to-back item only updates the payload at that edge.
   task automatic send_item(input logic [ID_W-1:0] id, input logic [ECHO_W-1:0] echo);
      int unsigned n;
      n = gap_len(tx_calm);
      if (n != 0) begin
         req_valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
      req_item.channel_id <= id;
      req_item.echo_width <= echo;
      req_valid           <= 1'b1;
      do @(posedge clock); while (req_stall);
      items_sent <= items_sent + 1;
   endtask

   // Drop valid and wait until every result has come back. The first edge
   // lets the checker count an item accepted at the calling edge.
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   // Only called with the block idle.
   task automatic write_default(input logic [ECHO_W-1:0] value);
      csr_wr_data <= value;
      csr_wr_en   <= 1'b1;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   initial begin : stimulus
      logic [ID_W-1:0]   known_id [MAX_CHANNELS_DEF];
      logic [ID_W-1:0]   id;
      logic [ECHO_W-1:0] base;
      logic [ECHO_W-1:0] echo;
      int unsigned       len;
      int unsigned       kind;
      int unsigned       r;
      int                chunk_sent;
      int                c;
      int                k;

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // ---- directed part, reset default of 1000 ----
      // Channel 63 claims slot 0: four warm-up items at full scale, then the
      // first full window (largest possible mean).
      repeat (5) send_item(6'd63, '1);
      // Floor rounding: window sum is no longer a multiple of the window size.
      send_item(6'd63, 20'd1);
      // Channel 0 in slot 1: a full window of zeros falls back to the default.
      repeat (5) send_item(6'd0, '0);
      // Ids 1..14 take slots 2..15, one warm-up item each; registry now full.
      for (k = 1; k <= 14; k++) send_item(ID_W'(k), 20'h55555 ^ ECHO_W'(k));
      // Unknown id with no free slot: lands in slot 0, window not cleared.
      send_item(6'd42, 20'h80000);

      known_id[0] = 6'd63;
      known_id[1] = 6'd0;
      for (k = 1; k <= 14; k++) known_id[k + 1] = ID_W'(k);

      // ---- random part ----
      // Bursts on one channel so windows fill and roll over. Most bursts hit a
      // registered channel; the rest use any id, and an unregistered one ends up in the shared slot 0.
      // Some bursts are all zeros to reach the zero-sum fallback.
      for (c = 0; c < CHUNKS; c++) begin
         wait_drained();
         case (c)
            0:       write_default('0);
            1:       write_default('1);
            2:       write_default(ECHO_W'($urandom));
            default: write_default(20'd1);
         endcase
         chunk_sent = 0;
         while (chunk_sent < CHUNK_ITEMS) begin
            kind = $urandom_range(0, 99);
            if (kind < 75) id = known_id[$urandom_range(0, MAX_CHANNELS_DEF - 1)];
            else           id = ID_W'($urandom_range(0, 63));
            len  = (kind % 8 == 0) ? $urandom_range(5, 7) : $urandom_range(1, 8);
            base = ECHO_W'($urandom);
            repeat (len) begin
               r = $urandom_range(0, 99);
               if (kind % 8 == 0 || r < 6) echo = '0;
               else if (r < 12)            echo = '1;
               else if (r < 55)            echo = base + ECHO_W'($urandom_range(0, 31));
               else                        echo = ECHO_W'($urandom);
               send_item(id, echo);
               chunk_sent++;
               if ($urandom_range(0, 39) == 0) tx_calm = !tx_calm;
            end
         end
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) $display("Verification passed");
      else $display("Verification failed");
      $finish;
   end

   // Result side: random stall, plus one long hold-off while the sender keeps
   // offering, so the output register and then the input side back up.
   initial begin : receiver
      int unsigned n;
      bit          held_long;
      bit          rx_calm;
      held_long = 1'b0;
      rx_calm   = 1'b0;
      forever begin
         @(posedge clock);
         if (!held_long && items_sent >= HOLD_AT) begin
            held_long = 1'b1;
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD) @(posedge clock);
            rsp_stall <= 1'b0;
         end else begin
            if ($urandom_range(0, 63) == 0) rx_calm = !rx_calm;
            n = gap_len(rx_calm);
            if (n != 0) begin
               rsp_stall <= 1'b1;
               repeat (n) @(posedge clock);
            end
            rsp_stall <= 1'b0;
         end
      end
   end

   // Watchdog: a lost result or a hung handshake ends the run here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

endmodule
